FILE: design/fcm_pkg.sv
// Shared types, codes and constants of the corner marker.
// No dependencies; imported by every module of the block.
package fcm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_SIDE      = 5;
    localparam int HV_W          = 13;
    localparam int ROW_W         = 12;
    localparam int COL_OUT_W     = 10;
    localparam int PIX_W         = 8;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 25;

    localparam logic [10:0] RST_WIDTH     = 11'd640;
    localparam logic [12:0] RST_HEIGHT    = 13'd480;
    localparam logic [24:0] RST_RESPONSE  = 25'd800;
    localparam logic [16:0] RST_ROUNDNESS = 17'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDNESS    = 8'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [19:0]        xx;
        logic [19:0]        yy;
        logic signed [20:0] xy;
    } t_prod;

    typedef struct packed {
        logic [24:0] response;
        logic [16:0] roundness;
    } t_thresh;

endpackage

FILE: design/fcm_queue.sv
// Short word queue between the front and back parts.
// Depends on fcm_pkg.
module fcm_queue import fcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end
endmodule

FILE: design/fcm_front.sv
// Front part: accepts input words, tracks frame position and drain,
// drops idle flushes and tags the frame-ending word. Depends on fcm_pkg.
module fcm_front import fcm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [$clog2(MAX_WIDTH):0]   i_wv,
    input  logic [HV_W-1:0]              i_hv,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [PIX_W-1:0]             i_pixel,
    output logic                         o_push,
    output t_item                        o_item,
    input  logic                         i_full
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int KW  = $clog2(3*MAX_WIDTH + 4);

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_drain;
    logic [KW-1:0]    r_dcnt;
    logic [KW-1:0]    delay;
    logic             acc, col_last, row_last, dcnt_last;

    assign delay     = (KW'(i_wv) << 1) + KW'(i_wv) + KW'(3);
    assign o_ready   = !i_full;
    assign acc       = i_valid && o_ready;
    assign col_last  = ({1'b0, r_col} == (i_wv - 1'b1));
    assign row_last  = ({1'b0, r_row} == (i_hv - 1'b1));
    assign dcnt_last = ((r_dcnt + 1'b1) == delay);
    assign o_push    = acc && (r_drain || i_command == CMD_PIXEL);
    assign o_item    = '{pixel: i_pixel, last: r_drain && dcnt_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= 1'b0;
            r_dcnt  <= '0;
        end else if (acc) begin
            if (!r_drain) begin
                if (i_command == CMD_PIXEL) begin
                    if (col_last) begin
                        r_col <= '0;
                        if (row_last) begin
                            r_row   <= '0;
                            r_drain <= 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end else if (dcnt_last) begin
                r_drain <= 1'b0;
                r_dcnt  <= '0;
            end else begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end
endmodule

FILE: design/fcm_back.sv
// Back part: line stores, Sobel gradients, 5x5 tensor sums, det/trace
// tests and the output register, run as a step sequencer. Depends on fcm_pkg.
module fcm_back import fcm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [$clog2(MAX_WIDTH):0]   i_wv,
    input  logic [HV_W-1:0]              i_hv,
    input  t_thresh                      i_thr,
    input  logic                         i_empty,
    input  t_item                        i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [COL_OUT_W-1:0]         o_column,
    output logic [ROW_W-1:0]             o_row,
    output logic [PIX_W-1:0]             o_grey,
    output logic                         o_is_corner,
    output logic                         o_last_of_frame
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WVW = CW + 1;
    localparam int KW  = $clog2(3*MAX_WIDTH + 4);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_TAP  = 11'b00000000010,
        S_GRD  = 11'b00000000100,
        S_MUL  = 11'b00000001000,
        S_COL  = 11'b00000010000,
        S_WIN  = 11'b00000100000,
        S_M1   = 11'b00001000000,
        S_M2   = 11'b00010000000,
        S_M3   = 11'b00100000000,
        S_M4   = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // line stores: one row of delay each
    logic [PIX_W-1:0] r_p1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_p2 [MAX_WIDTH];
    logic [PIX_W-1:0] r_p3 [MAX_WIDTH];
    t_prod            r_q1 [MAX_WIDTH];
    t_prod            r_q2 [MAX_WIDTH];
    t_prod            r_q3 [MAX_WIDTH];
    t_prod            r_q4 [MAX_WIDTH];

    logic [PIX_W-1:0] r_rd_p1, r_rd_p2, r_rd_p3;
    t_prod            r_rd_q1, r_rd_q2, r_rd_q3, r_rd_q4;

    t_item            r_item;
    logic [PIX_W-1:0] r_ta [3];
    logic [PIX_W-1:0] r_tb [3];
    logic [PIX_W-1:0] r_tc [3];
    logic [PIX_W-1:0] r_tg [4];

    logic signed [10:0] r_gx, r_gy;
    t_prod              r_prod;
    logic [22:0]        r_cxx [5];
    logic [22:0]        r_cyy [5];
    logic signed [23:0] r_cxy [5];
    logic [24:0]        r_sxx, r_syy;
    logic signed [25:0] r_sxy;
    logic [49:0]        r_m1, r_m2;
    logic [25:0]        r_tr;
    logic signed [51:0] r_det;
    logic [42:0]        r_rt;
    logic [50:0]        r_ttr;
    logic [46:0]        r_lo;
    logic [47:0]        r_hi;
    logic               r_resp, r_corner;

    logic [CW-1:0]     r_pcol;
    logic [KW-1:0]     r_k;
    logic [HV_W-1:0]   r_gr;
    logic [CW-1:0]     r_gc;
    logic [ROW_W-1:0]  r_qr;
    logic [CW-1:0]     r_qc;

    logic                 r_ov;
    logic [COL_OUT_W-1:0] r_ocol;
    logic [ROW_W-1:0]     r_orow;
    logic [PIX_W-1:0]     r_ogrey;
    logic                 r_ocorner, r_olast;

    logic [KW-1:0] delay;
    logic          g_act, q_act, g_border, q_inwin, out_free, step_done, tap_we, col_we;
    logic signed [11:0] sa0, sa2, sb0, sb2, sc0, sc2, gx_full, gy_full;
    logic signed [21:0] m_xx, m_yy, m_xy;
    logic signed [51:0] m_sq;
    logic [68:0]        rhs, lhs;

    assign delay    = (KW'(i_wv) << 1) + KW'(i_wv) + KW'(3);
    assign g_act    = (r_k >= (KW'(i_wv) + KW'(1)));
    assign q_act    = (r_k >= delay);
    assign g_border = (r_gr == '0) || (r_gc == '0)
                    || ((HV_W+1)'(r_gr) + 1'b1 >= (HV_W+1)'(i_hv))
                    || ((WVW+1)'(r_gc) + 1'b1 >= (WVW+1)'(i_wv));
    assign q_inwin  = (r_qr >= ROW_W'(2)) && (r_qc >= CW'(2))
                    && ((HV_W+1)'(r_qr) + (HV_W+1)'(2) < (HV_W+1)'(i_hv))
                    && ((WVW+1)'(r_qc) + (WVW+1)'(2) < (WVW+1)'(i_wv));
    assign out_free  = !r_ov || i_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign tap_we    = (r_state == S_TAP);
    assign col_we    = (r_state == S_COL);
    assign step_done = (r_state == S_OUT) && (!q_act || out_free);

    always_ff @(posedge i_clk) begin
        if (tap_we) r_p1[r_pcol] <= r_item.pixel;
        if (o_pop)  r_rd_p1 <= r_p1[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (tap_we) r_p2[r_pcol] <= r_rd_p1;
        if (o_pop)  r_rd_p2 <= r_p2[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (tap_we) r_p3[r_pcol] <= r_rd_p2;
        if (o_pop)  r_rd_p3 <= r_p3[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (col_we) r_q1[r_pcol] <= r_prod;
        if (o_pop)  r_rd_q1 <= r_q1[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (col_we) r_q2[r_pcol] <= r_rd_q1;
        if (o_pop)  r_rd_q2 <= r_q2[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (col_we) r_q3[r_pcol] <= r_rd_q2;
        if (o_pop)  r_rd_q3 <= r_q3[r_pcol];
    end
    always_ff @(posedge i_clk) begin
        if (col_we) r_q4[r_pcol] <= r_rd_q3;
        if (o_pop)  r_rd_q4 <= r_q4[r_pcol];
    end

    // a: row above, b: center row, c: row below; index 0 is rightmost
    always_comb begin
        sa0 = 12'(r_ta[0]); sa2 = 12'(r_ta[2]);
        sb0 = 12'(r_tb[0]); sb2 = 12'(r_tb[2]);
        sc0 = 12'(r_tc[0]); sc2 = 12'(r_tc[2]);
        gx_full = (sa0 + (sb0 <<< 1) + sc0) - (sa2 + (sb2 <<< 1) + sc2);
        gy_full = (sc2 + (12'(r_tc[1]) <<< 1) + sc0) - (sa2 + (12'(r_ta[1]) <<< 1) + sa0);
        m_xx = r_gx * r_gx;
        m_yy = r_gy * r_gy;
        m_xy = r_gx * r_gy;
        m_sq = r_sxy * r_sxy;
        rhs  = 69'({r_hi, 21'b0}) + 69'(r_lo);
        lhs  = {r_det[50:0], 18'b0};
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) r_item <= i_item;
            end
            S_TAP: begin
                r_ta[0] <= r_rd_p2; r_ta[1] <= r_ta[0]; r_ta[2] <= r_ta[1];
                r_tb[0] <= r_rd_p1; r_tb[1] <= r_tb[0]; r_tb[2] <= r_tb[1];
                r_tc[0] <= r_item.pixel; r_tc[1] <= r_tc[0]; r_tc[2] <= r_tc[1];
                r_tg[0] <= r_rd_p3; r_tg[1] <= r_tg[0];
                r_tg[2] <= r_tg[1]; r_tg[3] <= r_tg[2];
            end
            S_GRD: begin
                if (g_act && !g_border) begin
                    r_gx <= gx_full[10:0];
                    r_gy <= gy_full[10:0];
                end else begin
                    r_gx <= '0;
                    r_gy <= '0;
                end
            end
            S_MUL: begin
                r_prod.xx <= m_xx[19:0];
                r_prod.yy <= m_yy[19:0];
                r_prod.xy <= m_xy[20:0];
            end
            S_COL: begin
                r_cxx[0] <= 23'(r_prod.xx) + 23'(r_rd_q1.xx) + 23'(r_rd_q2.xx)
                          + 23'(r_rd_q3.xx) + 23'(r_rd_q4.xx);
                r_cyy[0] <= 23'(r_prod.yy) + 23'(r_rd_q1.yy) + 23'(r_rd_q2.yy)
                          + 23'(r_rd_q3.yy) + 23'(r_rd_q4.yy);
                r_cxy[0] <= 24'(r_prod.xy) + 24'(r_rd_q1.xy) + 24'(r_rd_q2.xy)
                          + 24'(r_rd_q3.xy) + 24'(r_rd_q4.xy);
                for (int i = 1; i < 5; i++) begin
                    r_cxx[i] <= r_cxx[i-1];
                    r_cyy[i] <= r_cyy[i-1];
                    r_cxy[i] <= r_cxy[i-1];
                end
            end
            S_WIN: begin
                r_sxx <= 25'(26'(r_cxx[0]) + 26'(r_cxx[1]) + 26'(r_cxx[2])
                           + 26'(r_cxx[3]) + 26'(r_cxx[4]));
                r_syy <= 25'(26'(r_cyy[0]) + 26'(r_cyy[1]) + 26'(r_cyy[2])
                           + 26'(r_cyy[3]) + 26'(r_cyy[4]));
                r_sxy <= 26'(r_cxy[0]) + 26'(r_cxy[1]) + 26'(r_cxy[2])
                       + 26'(r_cxy[3]) + 26'(r_cxy[4]);
            end
            S_M1: begin
                r_m1 <= 50'(r_sxx) * 50'(r_syy);
                r_m2 <= m_sq[49:0];
                r_tr <= 26'(r_sxx) + 26'(r_syy);
            end
            S_M2: begin
                r_det <= $signed({2'b00, r_m1}) - $signed({2'b00, r_m2});
                r_rt  <= 43'(i_thr.roundness) * 43'(r_tr);
                r_ttr <= 51'(i_thr.response) * 51'(r_tr);
            end
            S_M3: begin
                r_lo   <= 47'(r_rt[20:0]) * 47'(r_tr);
                r_hi   <= 48'(r_rt[42:21]) * 48'(r_tr);
                r_resp <= !r_det[51] && (r_det != '0) && (r_tr != '0)
                          && (r_det[50:0] > r_ttr);
            end
            S_M4: begin
                r_corner <= r_resp && q_inwin && (lhs > rhs);
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_pop) n_state = S_TAP;
            S_TAP:  n_state = S_GRD;
            S_GRD:  n_state = S_MUL;
            S_MUL:  n_state = S_COL;
            S_COL:  n_state = S_WIN;
            S_WIN:  n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_OUT;
            S_OUT:  if (step_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= S_IDLE;
            r_pcol  <= '0;
            r_k     <= '0;
            r_gr    <= '0;
            r_gc    <= '0;
            r_qr    <= '0;
            r_qc    <= '0;
        end else begin
            r_state <= n_state;
            if (step_done) begin
                if (r_item.last) begin
                    r_pcol <= '0;
                    r_k    <= '0;
                    r_gr   <= '0;
                    r_gc   <= '0;
                    r_qr   <= '0;
                    r_qc   <= '0;
                end else begin
                    if ({1'b0, r_pcol} == (i_wv - 1'b1)) r_pcol <= '0;
                    else r_pcol <= r_pcol + 1'b1;
                    if (!q_act) r_k <= r_k + 1'b1;
                    if (g_act) begin
                        if ({1'b0, r_gc} == (i_wv - 1'b1)) begin
                            r_gc <= '0;
                            r_gr <= r_gr + 1'b1;
                        end else begin
                            r_gc <= r_gc + 1'b1;
                        end
                    end
                    if (q_act) begin
                        if ({1'b0, r_qc} == (i_wv - 1'b1)) begin
                            r_qc <= '0;
                            r_qr <= r_qr + 1'b1;
                        end else begin
                            r_qc <= r_qc + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (step_done && q_act) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_done && q_act) begin
            r_ocol    <= COL_OUT_W'(r_qc);
            r_orow    <= r_qr;
            r_ogrey   <= r_tg[3];
            r_ocorner <= r_corner;
            r_olast   <= r_item.last;
        end
    end

    assign o_valid         = r_ov;
    assign o_column        = r_ocol;
    assign o_row           = r_orow;
    assign o_grey          = r_ogrey;
    assign o_is_corner     = r_ocorner;
    assign o_last_of_frame = r_olast;
endmodule

FILE: design/forstner_corner_marker_top.sv
// Forstner corner marker: 5x5 structure-tensor corner test on a raster stream.
// Instantiates fcm_front, fcm_queue and fcm_back; depends on fcm_pkg.
//
// Input words (i_valid/o_ready) carry a command bit and an 8-bit grey pixel in
// raster order. Results (o_valid/i_ready) give column, row, grey value, the
// corner mark and a last-of-frame flag; they trail the input by 3*width+3
// words, and flush words push the frame tail out after the last pixel.
// Flush words sent while the frame is still being filled are dropped.
// Registers are written over i_cfg_valid/o_cfg_ready with an index and data;
// writing width or height restarts the frame. Write only when idle.
// Each word passes through the back-end step sequencer (idle, tap, gradient,
// product, column, window, M1 to M4 and output) before the next is popped.
// A result shows on o_valid once the word that releases it has finished the
// output step.
// The front accepts words into a 4-deep queue while the back works, and a
// held result stalls only the back; the queue then fills and o_ready drops.
// Reset clears counters, queue and output valid, and loads register defaults
// (640, 480, 800, 32768). Line stores hold no reset; no clearing pass.
module forstner_corner_marker_top import fcm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COL_OUT_W-1:0]  o_column,
    output logic [ROW_W-1:0]      o_row,
    output logic [PIX_W-1:0]      o_grey,
    output logic                  o_is_corner,
    output logic                  o_last_of_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WVW = CW + 1;

    logic [10:0]      r_width;
    logic [HV_W-1:0]  r_height;
    t_thresh          r_thr;
    logic [WVW-1:0]   wv;
    logic [HV_W-1:0]  hv;
    logic             cfg_we, restart;
    logic             push, full, pop, empty;
    t_item            f_item, q_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_we && (i_cfg_index == REG_IMAGE_WIDTH
                                 || i_cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width         <= RST_WIDTH;
            r_height        <= RST_HEIGHT;
            r_thr.response  <= RST_RESPONSE;
            r_thr.roundness <= RST_ROUNDNESS;
        end else if (cfg_we) begin
            priority if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[10:0];
            end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data[HV_W-1:0];
            end else if (i_cfg_index == REG_RESPONSE) begin
                r_thr.response <= i_cfg_data[24:0];
            end else if (i_cfg_index == REG_ROUNDNESS) begin
                r_thr.roundness <= i_cfg_data[16:0];
            end else begin
            end
        end
    end

    always_comb begin
        if (r_width < 11'(MIN_SIDE)) wv = WVW'(MIN_SIDE);
        else if (14'(r_width) > 14'(MAX_WIDTH)) wv = WVW'(MAX_WIDTH);
        else wv = WVW'(r_width);
        if (r_height < HV_W'(MIN_SIDE)) hv = HV_W'(MIN_SIDE);
        else if (r_height > HV_W'(MAX_HEIGHT)) hv = HV_W'(MAX_HEIGHT);
        else hv = r_height;
    end

    fcm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_restart(restart), .i_wv(wv), .i_hv(hv),
        .i_valid, .o_ready, .i_command, .i_pixel,
        .o_push(push), .o_item(f_item), .i_full(full)
    );

    fcm_queue u_queue (
        .i_clk, .i_rst_n, .i_clear(restart),
        .i_push(push), .i_item(f_item), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_item(q_item)
    );

    fcm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_restart(restart), .i_wv(wv), .i_hv(hv), .i_thr(r_thr),
        .i_empty(empty), .i_item(q_item), .o_pop(pop),
        .o_valid, .i_ready, .o_column, .o_row, .o_grey, .o_is_corner, .o_last_of_frame
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full && !pop))
        else $error("word pushed into full queue");

    a_last_not_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame |-> !o_is_corner)
        else $error("frame corner pixel marked");

    a_corner_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_corner |-> o_column >= COL_OUT_W'(2) && o_row >= ROW_W'(2))
        else $error("corner marked near top or left edge");
endmodule

FILE: tb/forstner_corner_marker_top_test.sv
// Testbench for forstner_corner_marker_top: frame streams with a bit-exact corner predictor.
// Depends on fcm_pkg and the design sources; covers clamped sizes, thresholds, drain and stalls.
module forstner_corner_marker_top_test;
    import fcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 120;

    typedef struct packed {
        logic [COL_OUT_W-1:0] column;
        logic [ROW_W-1:0]     row;
        logic [PIX_W-1:0]     grey;
        logic                 corner;
        logic                 last;
    } t_mark;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_command;
    logic [PIX_W-1:0]      i_pixel;
    logic                  o_valid;
    logic                  i_ready;
    logic [COL_OUT_W-1:0]  o_column;
    logic [ROW_W-1:0]      o_row;
    logic [PIX_W-1:0]      o_grey;
    logic                  o_is_corner;
    logic                  o_last_of_frame;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    forstner_corner_marker_top i_dut (.*);

    // predictor state
    logic [7:0]  line_mem [0:15][0:1023];
    logic [10:0] reg_width;
    logic [12:0] reg_height;
    logic [24:0] reg_response;
    logic [16:0] reg_roundness;
    int          col_cnt, row_cnt, out_pos, word_cnt;
    bit          draining;
    t_mark       pending_marks[$];

    int  mismatches, words_sent, marks_seen, corners_seen, frames_done, stall_cnt;
    bit  tx_gaps, rx_gaps, hold_req;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int used_width();
        int w;
        w = reg_width;
        if (w < MIN_SIDE) w = MIN_SIDE;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = reg_height;
        if (h < MIN_SIDE) h = MIN_SIDE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame();
        col_cnt  = 0;
        row_cnt  = 0;
        out_pos  = 0;
        word_cnt = 0;
        draining = 0;
    endfunction

    function automatic int grey_at(int y, int x);
        return int'(line_mem[y % 16][x % 1024]);
    endfunction

    function automatic void sobel(int y, int x, int w, int h, output int gx, output int gy);
        gx = 0;
        gy = 0;
        if (y == 0 || x == 0 || y + 1 >= h || x + 1 >= w) return;
        gx = (grey_at(y-1, x+1) + 2*grey_at(y, x+1) + grey_at(y+1, x+1))
           - (grey_at(y-1, x-1) + 2*grey_at(y, x-1) + grey_at(y+1, x-1));
        gy = (grey_at(y+1, x-1) + 2*grey_at(y+1, x) + grey_at(y+1, x+1))
           - (grey_at(y-1, x-1) + 2*grey_at(y-1, x) + grey_at(y-1, x+1));
    endfunction

    function automatic logic corner_at(int r, int c, int w, int h);
        longint      sxx, syy, sxy, det;
        int          gx, gy;
        logic [63:0] trace, ud;
        logic [127:0] lhs, rhs;
        sxx = 0;
        syy = 0;
        sxy = 0;
        if (r < 2 || c < 2 || r + 2 >= h || c + 2 >= w) return 1'b0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                sobel(r - 2 + i, c - 2 + j, w, h, gx, gy);
                sxx += longint'(gx * gx);
                syy += longint'(gy * gy);
                sxy += longint'(gx) * longint'(gy);
            end
        end
        trace = sxx + syy;
        det   = sxx * syy - sxy * sxy;
        if (trace == 0 || det <= 0) return 1'b0;
        ud = det;
        if (!(ud > 64'(reg_response) * trace)) return 1'b0;
        lhs = 128'(ud) << 18;
        rhs = 128'(trace * trace) * 128'(reg_roundness);
        return lhs > rhs;
    endfunction

    // advance predictor by one accepted word
    function automatic void track_word(logic cmd, logic [7:0] px);
        int    w, h, r, c;
        t_mark m;
        w = used_width();
        h = used_height();
        if (!draining) begin
            if (cmd == CMD_FLUSH) return;
            line_mem[row_cnt % 16][col_cnt] = px;
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) draining = 1;
            end
        end
        word_cnt++;
        if (word_cnt <= 3 * w + 3) return;
        r = out_pos / w;
        c = out_pos % w;
        m.column = COL_OUT_W'(c);
        m.row    = ROW_W'(r);
        m.grey   = line_mem[r % 16][c];
        m.corner = corner_at(r, c, w, h);
        m.last   = (out_pos + 1 >= w * h);
        pending_marks.push_back(m);
        out_pos++;
        if (m.last) restart_frame();
    endfunction

    function automatic void track_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_IMAGE_WIDTH: begin
                reg_width = d[10:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                reg_height = d[12:0];
                restart_frame();
            end
            REG_RESPONSE:  reg_response  = d[24:0];
            REG_ROUNDNESS: reg_roundness = d[16:0];
            default: ;
        endcase
    endfunction

    // valid stays up after acceptance; the next word or settle() takes it over
    task automatic send_word(logic cmd, int px);
        @(negedge i_clk);
        while (tx_gaps && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_pixel   <= PIX_W'(px);
        do @(posedge i_clk); while (!o_ready);
        track_word(cmd, PIX_W'(px));
        words_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(d);
        do @(posedge i_clk); while (!o_cfg_ready);
        track_reg(idx, CFG_DATA_W'(d));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(int resp, int round);
        write_reg(REG_RESPONSE, resp);
        write_reg(REG_ROUNDNESS, round);
    endtask

    // full frame at the used size, then exactly enough drain words
    task automatic send_frame(bit square, int noise);
        int w, h, px;
        w = used_width();
        h = used_height();
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if ($urandom_range(99) < noise) send_word(CMD_FLUSH, $urandom_range(255));
                if (square)
                    px = (x >= w/3 && x < 2*w/3 + 1 && y >= h/3 && y < 2*h/3 + 1) ? 255 : 0;
                else
                    px = $urandom_range(255);
                send_word(CMD_PIXEL, px);
            end
        end
        for (int k = 0; k < 3 * w + 3; k++)
            send_word(($urandom_range(99) < noise) ? CMD_PIXEL : CMD_FLUSH,
                      $urandom_range(255));
        frames_done++;
    endtask

    task automatic test_register_limits();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 3);
        set_thresholds(0, 0);
        write_reg(8'd7, 25'h1FFFFFF);
        send_frame(1'b1, 10);
        send_word(CMD_FLUSH, 255);
    endtask

    task automatic test_corner_square();
        write_reg(REG_IMAGE_WIDTH, 9);
        write_reg(REG_IMAGE_HEIGHT, 9);
        set_thresholds(100, 16384);
        send_frame(1'b1, 0);
        send_frame(1'b1, 5);
        set_thresholds(33554431, 65536);
        send_frame(1'b1, 0);
        set_thresholds(0, 131071);
        send_frame(1'b0, 0);
    endtask

    task automatic test_random_frames();
        int start, n;
        start = words_sent;
        while (words_sent - start < 1000) begin
            tx_gaps = ($urandom_range(9) != 0);
            rx_gaps = tx_gaps;
            write_reg(REG_IMAGE_WIDTH, $urandom_range(16, 5));
            write_reg(REG_IMAGE_HEIGHT, $urandom_range(9, 5));
            set_thresholds(($urandom_range(9) == 0) ? $urandom_range(33554431)
                                                    : $urandom_range(3000),
                           $urandom_range(65536));
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(used_width() * used_height() + 20);
                for (int k = 0; k < n; k++)
                    send_word($urandom_range(99) < 15, $urandom_range(255));
            end else begin
                send_frame($urandom_range(4) == 0, 5);
            end
        end
        tx_gaps = 1;
        rx_gaps = 1;
    endtask

    task automatic test_backpressure();
        write_reg(REG_IMAGE_WIDTH, 6);
        write_reg(REG_IMAGE_HEIGHT, 6);
        set_thresholds(200, 8192);
        fork
            hold_req = 1;
            send_frame(1'b0, 0);
        join
    endtask

    task automatic test_wide_frames();
        tx_gaps = 0;
        rx_gaps = 0;
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 5);
        set_thresholds(500, 32768);
        for (int k = 0; k < 60; k++) send_word(CMD_PIXEL, $urandom_range(255));
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        for (int k = 0; k < 40; k++) send_word(CMD_PIXEL, $urandom_range(255));
        write_reg(REG_IMAGE_HEIGHT, 4096);
        for (int k = 0; k < 40; k++) send_word(CMD_PIXEL, $urandom_range(255));
        write_reg(REG_IMAGE_HEIGHT, 6);
        send_frame(1'b0, 0);
        tx_gaps = 1;
        rx_gaps = 1;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_mark want, got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_column, o_row, o_grey, o_is_corner, o_last_of_frame};
            marks_seen++;
            if (o_is_corner) corners_seen++;
            if (pending_marks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: col %0d row %0d grey %0d corner %0b last %0b",
                             got.column, got.row, got.grey, got.corner, got.last);
            end else begin
                want = pending_marks.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp col %0d row %0d grey %0d corner %0b last %0b,",
                                 want.column, want.row, want.grey, want.corner, want.last,
                                 " got col %0d row %0d grey %0d corner %0b last %0b",
                                 got.column, got.row, got.grey, got.corner, got.last);
                end
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_ready <= !(rx_gaps && $urandom_range(99) < 6);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = CMD_PIXEL;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tx_gaps     = 1;
        rx_gaps     = 1;
        hold_req    = 0;
        reg_width     = RST_WIDTH;
        reg_height    = RST_HEIGHT;
        reg_response  = RST_RESPONSE;
        reg_roundness = RST_ROUNDNESS;
        restart_frame();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_limits();
        test_corner_square();
        test_backpressure();
        test_random_frames();
        test_wide_frames();

        settle();
        $display("covered %0d input words, %0d frames, %0d results (%0d corners)",
                 words_sent, frames_done, marks_seen, corners_seen);
        $display("sizes clamped at both ends, thresholds zero to full scale, one long stall");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
